### hdl/mfvs_pkg.sv
package mfvs_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned FREQ_W   = 24;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned IPM_W    = 32;
    localparam int unsigned CNT_W    = 48;
    localparam int unsigned TSIZE_W  = 6;
    localparam int unsigned TIDX_W   = 5;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 7;

    // Percent scale and register reset values.
    localparam int unsigned PCT_FULL         = 100;
    localparam int unsigned CHANGE_THR_RESET = 10;
    localparam int unsigned WB_LIMIT_RESET   = 40;

    typedef enum logic [1:0] {
        ACT_BASELINE = 2'd0,
        ACT_EVAL     = 2'd1,
        ACT_CHOOSE   = 2'd2,
        ACT_LOAD     = 2'd3
    } action_t;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_PARTIAL    = 3'd1,
        CFG_TABLE_SIZE = 3'd2,
        CFG_CHANGE_THR = 3'd3,
        CFG_WB_LIMIT   = 3'd4
    } cfg_index_t;

endpackage

### hdl/mfvs_ram.sv
module mfvs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/mfvs_pct_div.sv
module mfvs_pct_div
    import mfvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] stall_cycles,
    input  logic [CNT_W-1:0] total_cycles,
    output logic             done,
    output logic [PCT_W-1:0] pct
);

    // Numerator is 100 * stall; a quotient that reaches 101 is clamped, so
    // only seven quotient bits are ever developed.
    localparam int NUM_W = CNT_W + PCT_W;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_STEP  = 3'b100
    } dstate_t;

    dstate_t            state_reg, state_next;
    logic               done_reg, done_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   den101_reg, den101_next;
    logic [NUM_W-1:0]   dsh_reg, dsh_next;
    logic               den_zero_reg, den_zero_next;
    logic [PCT_W-1:0]   q_reg, q_next;

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        den101_next   = den101_reg;
        dsh_next      = dsh_reg;
        den_zero_next = den_zero_reg;
        q_next        = q_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next      = NUM_W'(stall_cycles) * NUM_W'(PCT_FULL);
                    den101_next   = NUM_W'(total_cycles) * NUM_W'(PCT_FULL + 1);
                    dsh_next      = NUM_W'({total_cycles, 6'b0});
                    den_zero_next = (total_cycles == '0);
                    state_next    = D_CHECK;
                end
            end
            D_CHECK:
            begin
                if (den_zero_reg)
                begin
                    q_next     = '0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else if (rem_reg >= den101_reg)
                begin
                    q_next     = PCT_W'(PCT_FULL);
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    q_next     = '0;
                    cnt_next   = 3'd6;
                    state_next = D_STEP;
                end
            end
            D_STEP:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[PCT_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[PCT_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        den101_reg   <= den101_next;
        dsh_reg      <= dsh_next;
        den_zero_reg <= den_zero_next;
        q_reg        <= q_next;
    end

    assign done = done_reg;
    assign pct  = q_reg;

endmodule

### hdl/memory_freq_vote_selector.sv
// Channel  | Handshake            | Beat carries
// ---------+----------------------+-----------------------------------------------
// command  | start & !busy        | action, stall/total cycles, stall_pct, ipm,
//          |                      | writeback_pct, is_ddr, requested_freq, table
// result   | done (one cycle)     | mem_freq, stall/ok/ipm/wb flags
// config   | cfg_valid & cfg_ready| cfg_index, cfg_data
//
// A table load, and any command that bypasses the logic, gives its
// result in the cycle after acceptance. Baseline runs the seven-step serial
// percent divider, which ends early on an empty window or a clamp.
// Evaluation registers its products at acceptance. A frequency choice
// scans one entry per cycle on the single read port, with at most one extra read.
// Reset clears control, configuration and flag state; the table itself is
// not cleared and must be loaded before use. The receiver cannot stall:
// each result beat is shown for exactly one cycle while busy is already low,
// so a new command can be accepted in the same cycle.
module memory_freq_vote_selector
    import mfvs_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [CNT_W-1:0]    stall_cycles,
    input  logic [CNT_W-1:0]    total_cycles,
    input  logic [PCT_W-1:0]    stall_pct,
    input  logic [IPM_W-1:0]    instr_per_miss,
    input  logic [PCT_W-1:0]    writeback_pct,
    input  logic                is_ddr,
    input  logic [FREQ_W-1:0]   requested_freq,
    input  logic [TIDX_W-1:0]   table_index,
    input  logic [FREQ_W-1:0]   table_value,
    output logic                done,
    output logic [FREQ_W-1:0]   mem_freq,
    output logic                stall_flag,
    output logic                ok_flag,
    output logic                ipm_flag,
    output logic                wb_flag,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0]  cfg_data
);

    // Table address width, and a count width that holds both the table
    // depth itself and any value of the size register or load index.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > TSIZE_W) ? CW : TSIZE_W;

    // Evaluation product widths: 128 * 100 and 128 * 2^32 at most.
    localparam int SP_W = 15;
    localparam int IP_W = IPM_W + 8;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BASE  = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_FWAIT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [FREQ_W-1:0]   freq_out_reg, freq_out_next;
    action_t             act_reg, act_next;

    // Configuration registers.
    logic                enable_reg;
    logic                partial_reg;
    logic [TSIZE_W-1:0]  table_size_reg;
    logic [PCT_W-1:0]    thr_reg;
    logic [PCT_W-1:0]    wb_limit_reg;

    // Baseline and flag state.
    logic [PCT_W-1:0]    base_stall_reg, base_stall_next;
    logic [IPM_W-1:0]    base_ipm_reg, base_ipm_next;
    logic                stall_reg, stall_next;
    logic                ok_reg, ok_next;
    logic                ipm_reg, ipm_next;
    logic                wb_reg, wb_next;

    // Evaluation operands, products registered at acceptance.
    logic                ge_reg, ge_next;
    logic                cur_nz_reg, cur_nz_next;
    logic [SP_W-1:0]     sdiff100_reg, sdiff100_next;
    logic [SP_W-1:0]     sbase_reg, sbase_next;
    logic                ipm_lt_reg, ipm_lt_next;
    logic [IP_W-1:0]     idiff100_reg, idiff100_next;
    logic [IP_W-1:0]     ibase_reg, ibase_next;
    logic                wb_hit_reg, wb_hit_next;

    // Table scan.
    logic [FREQ_W-1:0]   req_reg, req_next;
    logic [FREQ_W-1:0]   prev_reg, prev_next;
    logic [XW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       ridx_reg, ridx_next;
    logic                rvalid_reg, rvalid_next;
    logic [AW-1:0]       fetch_addr_reg, fetch_addr_next;

    logic                accept;
    logic                active;
    logic [XW-1:0]       tsz_ext;
    logic [XW-1:0]       n_cur;
    logic [XW-1:0]       idx_ext;
    logic                idx_ok;
    logic [7:0]          thr_p1;
    logic [PCT_W-1:0]    sdiff;
    logic [IPM_W-1:0]    idiff;
    logic                rise;
    logic                hit;
    logic                last;
    logic                near_lo;

    logic                ram_we;
    logic [AW-1:0]       rd_addr;
    logic [FREQ_W-1:0]   rdata;
    logic                div_start;
    logic                div_done;
    logic [PCT_W-1:0]    div_pct;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign active    = enable_reg && !partial_reg;

    // Entries in use, saturated at the table depth.
    assign tsz_ext = XW'(table_size_reg);
    assign n_cur   = (tsz_ext > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : tsz_ext;
    assign idx_ext = XW'(table_index);
    assign idx_ok  = (idx_ext < XW'(TABLE_DEPTH));

    // A relative change floor(100*d/b) exceeds t exactly when 100*d >= (t+1)*b,
    // so every compare below works without a divider.
    assign thr_p1 = {1'b0, thr_reg} + 8'd1;
    assign sdiff  = (stall_pct >= base_stall_reg) ? (stall_pct - base_stall_reg)
                                                  : (base_stall_reg - stall_pct);
    assign idiff  = base_ipm_reg - instr_per_miss;

    assign rise    = (base_stall_reg == '0) ? cur_nz_reg : (sdiff100_reg >= sbase_reg);
    assign hit     = (rdata >= req_reg);
    assign last    = (XW'(ridx_reg) == (n_cur - XW'(1)));
    assign near_lo = ((req_reg - prev_reg) < (rdata - req_reg));

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        freq_out_next   = freq_out_reg;
        act_next        = act_reg;
        base_stall_next = base_stall_reg;
        base_ipm_next   = base_ipm_reg;
        stall_next      = stall_reg;
        ok_next         = ok_reg;
        ipm_next        = ipm_reg;
        wb_next         = wb_reg;
        ge_next         = ge_reg;
        cur_nz_next     = cur_nz_reg;
        sdiff100_next   = sdiff100_reg;
        sbase_next      = sbase_reg;
        ipm_lt_next     = ipm_lt_reg;
        idiff100_next   = idiff100_reg;
        ibase_next      = ibase_reg;
        wb_hit_next     = wb_hit_reg;
        req_next        = req_reg;
        prev_next       = prev_reg;
        addr_next       = addr_reg;
        ridx_next       = ridx_reg;
        rvalid_next     = 1'b0;
        fetch_addr_next = fetch_addr_reg;
        ram_we          = 1'b0;
        rd_addr         = addr_reg[AW-1:0];
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next      = action_t'(action);
                    freq_out_next = '0;
                    unique case (action_t'(action))
                        ACT_BASELINE:
                        begin
                            if (active)
                            begin
                                div_start     = 1'b1;
                                base_ipm_next = instr_per_miss;
                                state_next    = ST_BASE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ACT_EVAL:
                        begin
                            if (active)
                            begin
                                ge_next       = (stall_pct >= base_stall_reg);
                                cur_nz_next   = (stall_pct != '0);
                                sdiff100_next = SP_W'(sdiff) * SP_W'(PCT_FULL);
                                sbase_next    = SP_W'(thr_p1) * SP_W'(base_stall_reg);
                                ipm_lt_next   = (instr_per_miss < base_ipm_reg);
                                idiff100_next = IP_W'(idiff) * IP_W'(PCT_FULL);
                                ibase_next    = IP_W'(thr_p1) * IP_W'(base_ipm_reg);
                                wb_hit_next   = (writeback_pct > wb_limit_reg);
                                state_next    = ST_EVAL;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ACT_CHOOSE:
                        begin
                            req_next = requested_freq;
                            if (!active || !is_ddr || (n_cur == '0))
                            begin
                                freq_out_next = requested_freq;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                addr_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_LOAD:
                        begin
                            ram_we    = idx_ok;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BASE:
            begin
                if (div_done)
                begin
                    base_stall_next = div_pct;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                // A rise keeps ok as it was, a fall keeps stall as it was.
                if (ge_reg)
                begin
                    if (rise)
                    begin
                        stall_next = 1'b1;
                    end
                    else
                    begin
                        stall_next = 1'b0;
                        ok_next    = 1'b0;
                    end
                end
                else
                begin
                    if (sdiff100_reg >= sbase_reg)
                    begin
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        stall_next = 1'b0;
                        ok_next    = 1'b0;
                    end
                end
                ipm_next   = ipm_lt_reg && (idiff100_reg >= ibase_reg);
                wb_next    = wb_hit_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // One read is issued per cycle while entries remain; its data returns in the next cycle.
                if (addr_reg < n_cur)
                begin
                    addr_next   = addr_reg + XW'(1);
                    ridx_next   = addr_reg[AW-1:0];
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg)
                begin
                    if (hit)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if ((ridx_reg == '0) || last)
                        begin
                            freq_out_next = req_reg;
                        end
                        else if ((stall_reg && ipm_reg) || wb_reg)
                        begin
                            freq_out_next = rdata;
                        end
                        else if (stall_reg)
                        begin
                            if (near_lo)
                            begin
                                freq_out_next = rdata;
                            end
                            else
                            begin
                                fetch_addr_next = ridx_reg + AW'(1);
                                done_next       = 1'b0;
                                state_next      = ST_FETCH;
                            end
                        end
                        else if (ok_reg)
                        begin
                            if (!near_lo || (ridx_reg == AW'(1)))
                            begin
                                freq_out_next = prev_reg;
                            end
                            else
                            begin
                                fetch_addr_next = ridx_reg - AW'(2);
                                done_next       = 1'b0;
                                state_next      = ST_FETCH;
                            end
                        end
                        else
                        begin
                            freq_out_next = rdata;
                        end
                    end
                    else
                    begin
                        prev_next = rdata;
                        if (last)
                        begin
                            // No entry reaches the request.
                            freq_out_next = req_reg;
                            done_next     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr    = fetch_addr_reg;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                freq_out_next = rdata;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            rvalid_reg     <= 1'b0;
            enable_reg     <= 1'b0;
            partial_reg    <= 1'b0;
            table_size_reg <= '0;
            thr_reg        <= PCT_W'(CHANGE_THR_RESET);
            wb_limit_reg   <= PCT_W'(WB_LIMIT_RESET);
            base_stall_reg <= '0;
            base_ipm_reg   <= '0;
            stall_reg      <= 1'b0;
            ok_reg         <= 1'b0;
            ipm_reg        <= 1'b0;
            wb_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            rvalid_reg     <= rvalid_next;
            base_stall_reg <= base_stall_next;
            base_ipm_reg   <= base_ipm_next;
            stall_reg      <= stall_next;
            ok_reg         <= ok_next;
            ipm_reg        <= ipm_next;
            wb_reg         <= wb_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:     enable_reg     <= cfg_data[0];
                    CFG_PARTIAL:    partial_reg    <= cfg_data[0];
                    CFG_TABLE_SIZE: table_size_reg <= cfg_data[TSIZE_W-1:0];
                    CFG_CHANGE_THR: thr_reg        <= cfg_data[PCT_W-1:0];
                    CFG_WB_LIMIT:   wb_limit_reg   <= cfg_data[PCT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        freq_out_reg   <= freq_out_next;
        act_reg        <= act_next;
        ge_reg         <= ge_next;
        cur_nz_reg     <= cur_nz_next;
        sdiff100_reg   <= sdiff100_next;
        sbase_reg      <= sbase_next;
        ipm_lt_reg     <= ipm_lt_next;
        idiff100_reg   <= idiff100_next;
        ibase_reg      <= ibase_next;
        wb_hit_reg     <= wb_hit_next;
        req_reg        <= req_next;
        prev_reg       <= prev_next;
        addr_reg       <= addr_next;
        ridx_reg       <= ridx_next;
        fetch_addr_reg <= fetch_addr_next;
    end

    mfvs_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (table_value),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    mfvs_pct_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .stall_cycles (stall_cycles),
        .total_cycles (total_cycles),
        .done         (div_done),
        .pct          (div_pct)
    );

    assign done       = done_reg;
    assign mem_freq   = freq_out_reg;
    assign stall_flag = stall_reg;
    assign ok_flag    = ok_reg;
    assign ipm_flag   = ipm_reg;
    assign wb_flag    = wb_reg;

    // A result beat only appears once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // A table load completes in the cycle after it is taken.
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_LOAD)) |=> done)
        else $error("table load did not complete in one cycle");

    // Only a frequency choice reports a nonzero frequency.
    a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (act_reg != ACT_CHOOSE)) |-> (mem_freq == '0))
        else $error("nonzero frequency on a non-choose beat");

    // Returned scan data always belongs to an entry in use.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && rvalid_reg) |-> (XW'(ridx_reg) < n_cur))
        else $error("scan read past the table size");

    // The baseline percent is clamped to full scale.
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_pct <= PCT_W'(PCT_FULL)))
        else $error("baseline percent above full scale");

endmodule

### test/memory_freq_vote_selector_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the memory frequency vote selector. Commands are
// pushed through the start/busy handshake, with random idle gaps or back
// to back; every accepted command runs through an in-bench predictor of
// the selector, and each done beat is compared to the oldest predicted one.
module memory_freq_vote_selector_tb;
    import mfvs_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    // One command beat, one field per port.
    typedef struct {
        action_t             action;
        logic [CNT_W-1:0]    stall_cycles;
        logic [CNT_W-1:0]    total_cycles;
        logic [PCT_W-1:0]    stall_pct;
        logic [IPM_W-1:0]    instr_per_miss;
        logic [PCT_W-1:0]    writeback_pct;
        logic                is_ddr;
        logic [FREQ_W-1:0]   requested_freq;
        logic [TIDX_W-1:0]   table_index;
        logic [FREQ_W-1:0]   table_value;
    } vote_cmd_t;

    // One result beat.
    typedef struct {
        logic [FREQ_W-1:0] mem_freq;
        logic              stall;
        logic              ok;
        logic              ipm;
        logic              wb;
    } vote_result_t;

    // Predictor of the selector plus the queue of results it still owes.
    class freq_vote_scoreboard;
        bit                 enable_r;
        bit                 partial_r;
        bit [TSIZE_W-1:0]   table_size_r;
        bit [PCT_W-1:0]     change_thr_r;
        bit [PCT_W-1:0]     wb_limit_r;
        bit [PCT_W-1:0]     base_stall;
        bit [IPM_W-1:0]     base_ipm;
        bit                 stall_st;
        bit                 ok_st;
        bit                 ipm_st;
        bit                 wb_st;
        bit [FREQ_W-1:0]    freq_tab [DEPTH];
        vote_result_t       expected_votes [$];
        int unsigned        mismatches;

        function new();
            enable_r     = 1'b0;
            partial_r    = 1'b0;
            table_size_r = '0;
            change_thr_r = PCT_W'(CHANGE_THR_RESET);
            wb_limit_r   = PCT_W'(WB_LIMIT_RESET);
            base_stall   = '0;
            base_ipm     = '0;
            stall_st     = 1'b0;
            ok_st        = 1'b0;
            ipm_st       = 1'b0;
            wb_st        = 1'b0;
            mismatches   = 0;
        endfunction

        function bit is_active();
            return enable_r && !partial_r;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_D_W-1:0] data);
            case (idx)
                CFG_ENABLE:     enable_r     = data[0];
                CFG_PARTIAL:    partial_r    = data[0];
                CFG_TABLE_SIZE: table_size_r = data[TSIZE_W-1:0];
                CFG_CHANGE_THR: change_thr_r = data[PCT_W-1:0];
                CFG_WB_LIMIT:   wb_limit_r   = data[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function void record_baseline(vote_cmd_t c);
            longint unsigned pct;
            pct = 0;
            if (c.total_cycles != 0)
                pct = (longint'(c.stall_cycles) * PCT_FULL) / longint'(c.total_cycles);
            if (pct > PCT_FULL)
                pct = PCT_FULL;
            base_stall = pct[PCT_W-1:0];
            base_ipm   = c.instr_per_miss;
        endfunction

        function void eval_sample(vote_cmd_t c);
            longint unsigned cur;
            longint unsigned base;
            longint unsigned bipm;
            bit              rise;
            cur  = c.stall_pct;
            base = base_stall;
            if (cur >= base) begin
                // A zero baseline has no relative scale: any rise at all counts.
                if (base == 0)
                    rise = cur > 0;
                else
                    rise = ((cur - base) * PCT_FULL) / base > change_thr_r;
                if (rise) begin
                    stall_st = 1'b1;
                end else begin
                    stall_st = 1'b0;
                    ok_st    = 1'b0;
                end
            end else begin
                if (((base - cur) * PCT_FULL) / base > change_thr_r) begin
                    ok_st = 1'b1;
                end else begin
                    stall_st = 1'b0;
                    ok_st    = 1'b0;
                end
            end
            bipm = base_ipm;
            if (c.instr_per_miss < base_ipm)
                ipm_st = ((bipm - c.instr_per_miss) * PCT_FULL) / bipm > change_thr_r;
            else
                ipm_st = 1'b0;
            wb_st = c.writeback_pct > wb_limit_r;
        endfunction

        function bit [FREQ_W-1:0] choose_vote(bit [FREQ_W-1:0] req, bit ddr);
            int unsigned      n;
            int unsigned      i;
            int unsigned      j;
            bit [FREQ_W-1:0]  dpre;
            bit [FREQ_W-1:0]  dpost;
            if (!is_active() || !ddr)
                return req;
            n = (table_size_r > DEPTH) ? DEPTH : table_size_r;
            i = 0;
            while (i < n && freq_tab[i] < req)
                i++;
            if (i >= n || i == 0 || i == n - 1)
                return req;
            if ((stall_st && ipm_st) || wb_st)
                return freq_tab[i];
            dpre  = req - freq_tab[i-1];
            dpost = freq_tab[i] - req;
            j = (dpre < dpost) ? i - 1 : i;
            if (stall_st)
                return freq_tab[j+1];
            if (ok_st)
                return freq_tab[(j == 0) ? 0 : j - 1];
            return freq_tab[i];
        endfunction

        function void note_command(vote_cmd_t c);
            vote_result_t r;
            r.mem_freq = '0;
            case (c.action)
                ACT_BASELINE: if (is_active()) record_baseline(c);
                ACT_EVAL:     if (is_active()) eval_sample(c);
                ACT_CHOOSE:   r.mem_freq = choose_vote(c.requested_freq, c.is_ddr);
                default:      freq_tab[c.table_index] = c.table_value;
            endcase
            r.stall = stall_st;
            r.ok    = ok_st;
            r.ipm   = ipm_st;
            r.wb    = wb_st;
            expected_votes.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(vote_result_t got);
            vote_result_t want;
            if (expected_votes.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, mem_freq %0h",
                                          got.mem_freq));
                return;
            end
            want = expected_votes.pop_front();
            if (got.mem_freq !== want.mem_freq)
                report_mismatch($sformatf("mem_freq %0h, predicted %0h",
                                          got.mem_freq, want.mem_freq));
            if (got.stall !== want.stall)
                report_mismatch($sformatf("stall_flag %b, predicted %b", got.stall, want.stall));
            if (got.ok !== want.ok)
                report_mismatch($sformatf("ok_flag %b, predicted %b", got.ok, want.ok));
            if (got.ipm !== want.ipm)
                report_mismatch($sformatf("ipm_flag %b, predicted %b", got.ipm, want.ipm));
            if (got.wb !== want.wb)
                report_mismatch($sformatf("wb_flag %b, predicted %b", got.wb, want.wb));
        endtask
    endclass

    // Every input starts at a known value so the block never sees X.
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [1:0]          action         = '0;
    logic [CNT_W-1:0]    stall_cycles   = '0;
    logic [CNT_W-1:0]    total_cycles   = '0;
    logic [PCT_W-1:0]    stall_pct      = '0;
    logic [IPM_W-1:0]    instr_per_miss = '0;
    logic [PCT_W-1:0]    writeback_pct  = '0;
    logic                is_ddr         = 1'b0;
    logic [FREQ_W-1:0]   requested_freq = '0;
    logic [TIDX_W-1:0]   table_index    = '0;
    logic [FREQ_W-1:0]   table_value    = '0;
    logic                done;
    logic [FREQ_W-1:0]   mem_freq;
    logic                stall_flag;
    logic                ok_flag;
    logic                ipm_flag;
    logic                wb_flag;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [CFG_IX_W-1:0] cfg_index      = '0;
    logic [CFG_D_W-1:0]  cfg_data       = '0;

    freq_vote_scoreboard sb = new();

    // When set, the sender issues commands back to back with no idle gap.
    bit burst_mode = 1'b0;

    memory_freq_vote_selector #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .stall_cycles   (stall_cycles),
        .total_cycles   (total_cycles),
        .stall_pct      (stall_pct),
        .instr_per_miss (instr_per_miss),
        .writeback_pct  (writeback_pct),
        .is_ddr         (is_ddr),
        .requested_freq (requested_freq),
        .table_index    (table_index),
        .table_value    (table_value),
        .done           (done),
        .mem_freq       (mem_freq),
        .stall_flag     (stall_flag),
        .ok_flag        (ok_flag),
        .ipm_flag       (ipm_flag),
        .wb_flag        (wb_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver cannot push back, so every done beat is taken at the edge
    // that ends it. Outputs are read before the edge takes effect.
    always @(posedge clk) begin : result_monitor
        vote_result_t got;
        if (rst_n && done) begin
            got.mem_freq = mem_freq;
            got.stall    = stall_flag;
            got.ok       = ok_flag;
            got.ipm      = ipm_flag;
            got.wb       = wb_flag;
            sb.check_result(got);
        end
    end

    function automatic logic [FREQ_W-1:0] sat_freq(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(FREQ_MAX))
            return FREQ_MAX;
        return v[FREQ_W-1:0];
    endfunction

    function automatic int clamp_pct(int v);
        if (v < 0)
            return 0;
        if (v > 127)
            return 127;
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CNT_W-1:0];
    endfunction

    // Every field gets random content, so the fields that an action does not
    // use still toggle on the wires.
    function automatic vote_cmd_t random_noise();
        vote_cmd_t c;
        c.action         = action_t'($urandom_range(0, 3));
        c.stall_cycles   = rand48();
        c.total_cycles   = rand48();
        c.stall_pct      = PCT_W'($urandom_range(0, 127));
        c.instr_per_miss = $urandom;
        c.writeback_pct  = PCT_W'($urandom_range(0, 127));
        c.is_ddr         = 1'($urandom_range(0, 1));
        c.requested_freq = FREQ_W'($urandom);
        c.table_index    = TIDX_W'($urandom);
        c.table_value    = FREQ_W'($urandom);
        return c;
    endfunction

    function automatic vote_cmd_t cmd_baseline(logic [CNT_W-1:0] st, logic [CNT_W-1:0] tot,
                                               logic [IPM_W-1:0] ipm);
        vote_cmd_t c;
        c = random_noise();
        c.action         = ACT_BASELINE;
        c.stall_cycles   = st;
        c.total_cycles   = tot;
        c.instr_per_miss = ipm;
        return c;
    endfunction

    function automatic vote_cmd_t cmd_eval(int cur, longint ipm, int wb);
        vote_cmd_t c;
        c = random_noise();
        c.action         = ACT_EVAL;
        c.stall_pct      = PCT_W'(clamp_pct(cur));
        c.instr_per_miss = (ipm < 0) ? '0 : (ipm > 64'hFFFF_FFFF) ? '1 : ipm[IPM_W-1:0];
        c.writeback_pct  = PCT_W'(clamp_pct(wb));
        return c;
    endfunction

    function automatic vote_cmd_t cmd_choose(logic [FREQ_W-1:0] req, logic ddr);
        vote_cmd_t c;
        c = random_noise();
        c.action         = ACT_CHOOSE;
        c.requested_freq = req;
        c.is_ddr         = ddr;
        return c;
    endfunction

    function automatic vote_cmd_t cmd_load(int idx, logic [FREQ_W-1:0] val);
        vote_cmd_t c;
        c = random_noise();
        c.action      = ACT_LOAD;
        c.table_index = TIDX_W'(idx);
        c.table_value = val;
        return c;
    endfunction

    // Baseline windows: empty windows, more stalls than cycles, full-range
    // counters, and realistic stall ratios.
    function automatic vote_cmd_t gen_baseline();
        logic [CNT_W-1:0] tot;
        logic [CNT_W-1:0] st;
        logic [63:0]      w;
        logic [IPM_W-1:0] ipm;
        tot = rand48() >> $urandom_range(0, 44);
        case ($urandom_range(0, 5))
            0: begin
                tot = '0;
                st  = rand48();
            end
            1: st = tot + CNT_W'($urandom_range(1, 1000));
            2: begin
                st  = rand48();
                tot = rand48();
            end
            default: begin
                w  = (64'(tot) * $urandom_range(0, 100)) / 100;
                st = w[CNT_W-1:0];
            end
        endcase
        case ($urandom_range(0, 7))
            0:       ipm = '0;
            1, 2:    ipm = $urandom;
            default: ipm = $urandom_range(1, 5000);
        endcase
        return cmd_baseline(st, tot, ipm);
    endfunction

    // Samples cluster around the baseline and around the threshold edges so
    // that the flags are set and cleared often.
    function automatic vote_cmd_t gen_eval();
        int     b;
        int     thr;
        int     cur;
        longint bi;
        longint ipm;
        int     wb;
        b   = sb.base_stall;
        thr = sb.change_thr_r;
        bi  = sb.base_ipm;
        case ($urandom_range(0, 5))
            0:       cur = $urandom_range(0, 127);
            1:       cur = b + (b * thr) / 100 + int'($urandom_range(0, 2)) - 1;
            2:       cur = b - (b * thr) / 100 + int'($urandom_range(0, 2)) - 1;
            3:       cur = b;
            default: cur = b + int'($urandom_range(0, 60)) - 30;
        endcase
        case ($urandom_range(0, 5))
            0:       ipm = $urandom;
            1:       ipm = bi - (bi * (thr + int'($urandom_range(0, 2)) - 1)) / 100;
            2:       ipm = bi + $urandom_range(0, 1000);
            3:       ipm = 0;
            default: ipm = bi - (bi / 100) * $urandom_range(0, 60);
        endcase
        if ($urandom_range(0, 2) == 0)
            wb = $urandom_range(0, 127);
        else
            wb = int'(sb.wb_limit_r) + int'($urandom_range(0, 4)) - 2;
        return cmd_eval(cur, ipm, wb);
    endfunction

    // Requests mostly land on, near, or between loaded entries.
    function automatic vote_cmd_t gen_choose();
        int unsigned       n;
        int unsigned       k;
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [FREQ_W-1:0] req;
        n = (sb.table_size_r > DEPTH) ? DEPTH : sb.table_size_r;
        if (n == 0)
            n = DEPTH;
        k  = $urandom_range(0, n - 1);
        lo = sb.freq_tab[k];
        hi = (k + 1 < DEPTH) ? sb.freq_tab[k+1] : FREQ_MAX;
        case ($urandom_range(0, 9))
            0:       req = FREQ_W'($urandom);
            1:       req = '0;
            2:       req = FREQ_MAX;
            3, 4:    req = lo;
            5, 6:    req = sat_freq(longint'(lo) + int'($urandom_range(0, 4000)) - 2000);
            default: req = FREQ_W'($urandom_range(lo, hi));
        endcase
        return cmd_choose(req, $urandom_range(0, 7) != 0);
    endfunction

    // Loads mostly keep the table ascending; a few scatter it.
    function automatic vote_cmd_t gen_load();
        int unsigned       idx;
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [FREQ_W-1:0] v;
        idx = $urandom_range(0, DEPTH - 1);
        lo  = (idx == 0) ? '0 : sb.freq_tab[idx-1];
        hi  = (idx == DEPTH - 1) ? FREQ_MAX : sb.freq_tab[idx+1];
        if ($urandom_range(0, 9) == 0 || lo > hi)
            v = FREQ_W'($urandom);
        else
            v = FREQ_W'($urandom_range(lo, hi));
        return cmd_load(idx, v);
    endfunction

    // Drives one command beat. After an optional idle gap, start is raised with
    // the payload and held until the block accepts it (start high, busy low).
    // Start is left high on return; the next call either replaces the payload
    // in the same step or lowers start for its own gap.
    task automatic send_command(vote_cmd_t c);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        action         <= c.action;
        stall_cycles   <= c.stall_cycles;
        total_cycles   <= c.total_cycles;
        stall_pct      <= c.stall_pct;
        instr_per_miss <= c.instr_per_miss;
        writeback_pct  <= c.writeback_pct;
        is_ddr         <= c.is_ddr;
        requested_freq <= c.requested_freq;
        table_index    <= c.table_index;
        table_value    <= c.table_value;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
    endtask

    // Stops issuing and waits until every predicted result beat has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.expected_votes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write beat; cfg_valid stays high for a following write.
    task automatic put_reg(cfg_index_t idx, logic [CFG_D_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // All five registers, written back to back while the block is idle.
    task automatic write_config(bit en, bit part, logic [CFG_D_W-1:0] tsize,
                                logic [CFG_D_W-1:0] thr, logic [CFG_D_W-1:0] wb);
        put_reg(CFG_ENABLE, CFG_D_W'(en));
        put_reg(CFG_PARTIAL, CFG_D_W'(part));
        put_reg(CFG_TABLE_SIZE, tsize);
        put_reg(CFG_CHANGE_THR, thr);
        put_reg(CFG_WB_LIMIT, wb);
        cfg_valid <= 1'b0;
    endtask

    // Fills the whole table in ascending order. With pin_ends the first entry
    // is zero and the last is the largest frequency the field can hold.
    task automatic load_ascending(bit pin_ends);
        logic [FREQ_W-1:0] v;
        v = pin_ends ? '0 : FREQ_W'($urandom_range(0, 20000));
        for (int k = 0; k < DEPTH; k++) begin
            if (pin_ends && k == DEPTH - 1)
                v = FREQ_MAX;
            send_command(cmd_load(k, v));
            v = sat_freq(longint'(v) + $urandom_range(1, 500000));
        end
    endtask

    initial begin
        logic [FREQ_W-1:0] t_mid;
        int unsigned       r;
        bit                en;
        bit                part;
        logic [CFG_D_W-1:0] tsize;
        logic [CFG_D_W-1:0] thr;
        logic [CFG_D_W-1:0] wb;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Under the reset configuration the block is disabled: the whole table
        // is loaded first, so no later scan can ever touch an unwritten entry,
        // and samples are ignored while requests pass through.
        load_ascending(1'b1);
        send_command(cmd_baseline(48'd10, 48'd20, 32'd100));
        send_command(cmd_eval(90, 0, 100));
        send_command(cmd_choose(sb.freq_tab[10] - 24'd1, 1'b1));
        drain_results();

        write_config(1'b1, 1'b0, 7'd32, 7'd10, 7'd40);

        // An empty window gives a zero baseline; then a zero sample clears the
        // stall flags and any nonzero sample counts as a rise.
        send_command(cmd_baseline(rand48(), '0, '0));
        send_command(cmd_eval(0, 0, 41));
        send_command(cmd_eval(5, 0, 40));
        // Full-scale counters, then more stalls than cycles: both give a full-scale percent.
        send_command(cmd_baseline('1, '1, '1));
        send_command(cmd_baseline(48'd1000, 48'd10, 32'd5000));
        // A stall percent beyond a hundred is taken as given.
        send_command(cmd_eval(127, 0, 127));
        // Writeback over its limit returns the found entry as is.
        t_mid = sb.freq_tab[10] + (sb.freq_tab[11] - sb.freq_tab[10]) / 2 + 24'd1;
        send_command(cmd_choose(t_mid, 1'b1));
        send_command(cmd_baseline(48'd1, 48'd2, 32'd1000));
        send_command(cmd_eval(70, 950, 0));
        send_command(cmd_choose(sb.freq_tab[5] + 24'd3, 1'b1));
        // A fall sets ok and leaves stall; a small change clears both.
        send_command(cmd_eval(30, 1000, 0));
        send_command(cmd_eval(52, 1000, 0));
        send_command(cmd_eval(30, 1000, 0));
        send_command(cmd_choose(sb.freq_tab[1], 1'b1));
        // Just above entry zero: the nearest entry is zero and ok stays there.
        send_command(cmd_choose(sb.freq_tab[0] + 24'd1, 1'b1));
        // First entry, last entry and a non-DDR request pass through.
        send_command(cmd_choose('0, 1'b1));
        send_command(cmd_choose(FREQ_MAX, 1'b1));
        send_command(cmd_choose(t_mid, 1'b0));
        send_command(cmd_eval(50, 800, 0));
        send_command(cmd_choose(t_mid, 1'b1));
        send_command(cmd_eval(70, 800, 0));
        send_command(cmd_choose(t_mid, 1'b1));
        send_command(cmd_load(DEPTH - 1, FREQ_MAX));
        drain_results();

        // A request above every valid entry of a short table passes through.
        write_config(1'b1, 1'b0, 7'd5, 7'd10, 7'd40);
        send_command(cmd_choose(sb.freq_tab[10], 1'b1));
        drain_results();

        // Random phases, each under its own register setting, extremes first.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:  begin en = 1; part = 0; tsize = 32;  thr = 10;  wb = 40;  end
                1:  begin en = 1; part = 0; tsize = 32;  thr = 0;   wb = 0;   end
                2:  begin en = 1; part = 0; tsize = $urandom_range(3, 31);
                          thr = $urandom_range(0, 100); wb = $urandom_range(0, 100); end
                3:  begin en = 1; part = 1; tsize = 32;  thr = 10;  wb = 40;  end
                4:  begin en = 0; part = 0; tsize = 32;  thr = 10;  wb = 40;  end
                5:  begin en = 1; part = 0; tsize = 63;  thr = 100; wb = 100; end
                6:  begin en = 1; part = 0; tsize = 2;   thr = 5;   wb = 50;  end
                7:  begin en = 1; part = 0; tsize = 0;   thr = 20;  wb = 60;  end
                8:  begin en = 1; part = 0; tsize = 33;  thr = 127; wb = 127; end
                9:  begin en = 1; part = 0; tsize = 1;   thr = 15;  wb = 30;  end
                default: begin
                    en = 1; part = 0; tsize = $urandom_range(3, 32);
                    thr = $urandom_range(0, 40); wb = $urandom_range(0, 127);
                end
            endcase
            write_config(en, part, tsize, thr, wb);
            if (ph % 3 == 0)
                load_ascending(1'b0);
            burst_mode = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(0, 39) == 0)
                    burst_mode = !burst_mode;
                // Now and then the sender holds off until every result is in.
                if (n == 40 && ph % 4 == 1)
                    drain_results();
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_command(random_noise());
                else if (r < 18)
                    send_command(gen_baseline());
                else if (r < 46)
                    send_command(gen_eval());
                else if (r < 88)
                    send_command(gen_choose());
                else
                    send_command(gen_load());
            end
            drain_results();
        end

        // Everything is accepted and answered; give the block a little more
        // time in case a stray beat follows.
        burst_mode = 1'b0;
        repeat (40) @(posedge clk);
        if (sb.expected_votes.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.expected_votes.size()));
        if (sb.mismatches == 0)
            $display("** memory_freq_vote_selector: PASSED **");
        else
            $display("** memory_freq_vote_selector: FAILED **");
        $finish;
    end

    // Watchdog: a hung handshake or a lost result beat ends the run here.
    initial begin
        #5_000_000;
        $display("** memory_freq_vote_selector: FAILED **");
        $finish;
    end

endmodule
